/* src/assert_macros.svh */
// Assertion macros shared by the turbo code block segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TCBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define TCBS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TCBS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/tcbs_pkg.sv */
// Shared types, constants and turbo interleaver table functions.
package tcbs_pkg;

  localparam int TCBS_TB_SIZE_WIDTH = 20;
  localparam int TCBS_CRC_BITS      = 24;
  localparam int TCBS_MAX_K         = 6144;
  localparam int TCBS_CFG_RESET     = 6144;
  localparam int TCBS_CNT_W         = 15;
  localparam int TCBS_K_W           = 13;

  typedef logic [1:0] tcbs_kind_t;
  localparam tcbs_kind_t KIND_OK   = 2'd0;
  localparam tcbs_kind_t KIND_ZERO = 2'd1;
  localparam tcbs_kind_t KIND_ERR  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       one_blk;
    logic       div1_go;
    logic       take_c;
    logic       div2_go;
    logic       take_need;
    logic       take_idx;
    logic       take_prod;
    logic       take_e;
    logic       take_out;
    tcbs_kind_t kind;
  } tcbs_cmd_t;

  typedef struct packed {
    logic zero;
    logic fits;
    logic z_small;
    logic c_over;
    logic need_big;
    logic idx_zero;
    logic multi;
    logic div_done;
    logic div_busy;
    logic out_free;
  } tcbs_sts_t;

  // Interleaver size at a table index.
  function automatic logic [12:0] tcbs_tc_size(input logic [7:0] idx);
    logic [12:0] i13;
    i13 = 13'(idx);
    if (idx < 8'd60) begin
      return 13'd40 + (i13 << 3);
    end else if (idx < 8'd92) begin
      return 13'd512 + ((i13 - 13'd59) << 4);
    end else if (idx < 8'd124) begin
      return 13'd1024 + ((i13 - 13'd91) << 5);
    end else begin
      return 13'd2048 + ((i13 - 13'd123) << 6);
    end
  endfunction

  // Index of the smallest interleaver size that is at least n (n <= 6144).
  function automatic logic [7:0] tcbs_tc_index(input logic [12:0] n);
    if (n <= 13'd40) begin
      return 8'd0;
    end else if (n <= 13'd512) begin
      return 8'((n - 13'd33) >> 3);
    end else if (n <= 13'd1024) begin
      return 8'd59 + 8'((n - 13'd497) >> 4);
    end else if (n <= 13'd2048) begin
      return 8'd91 + 8'((n - 13'd993) >> 5);
    end else begin
      return 8'd123 + 8'((n - 13'd1985) >> 6);
    end
  endfunction

endpackage

/* src/turbo_code_block_segmenter_core.sv */
// Top level of the turbo code block segmenter: APB register, controller and datapath.
//
//   Channel   Direction  Handshake            Word contents
//   in_       input      in_valid/in_ready    transport block size
//   out_      output     out_valid/out_ready  status, C, K+, K-, indices, C+, C-, F
//   cfg_      APB slave  psel/penable/pready  max_block_size at byte address 0
//
// One word is processed at a time. A single code block skips the divider;
// a split block makes two divider passes, one for C and one for ceil(B'/C).
// rst_n is synchronous and active low; it restores max_block_size to 6144.
// A finished word waits in the output register while the next word is accepted;
// a new result is loaded only once that register is free.
module turbo_code_block_segmenter_core
  import tcbs_pkg::*;
#(
  parameter int TB_SIZE_WIDTH = TCBS_TB_SIZE_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input word
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TB_SIZE_WIDTH-1:0] in_tb_size,
  // Result word
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic [14:0]              out_block_count,
  output logic [12:0]              out_large_size,
  output logic [7:0]               out_large_index,
  output logic [12:0]              out_small_size,
  output logic [7:0]               out_small_index,
  output logic [14:0]              out_large_count,
  output logic [14:0]              out_small_count,
  output logic [5:0]               out_filler_bits,
  // Configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [2:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

`include "assert_macros.svh"

  // The only register sits at byte address 0; address bit 2 selects the
  // (empty) next word, so writes there are ignored and reads return zero.
  logic [12:0] max_block_size_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_block_size_r <= 13'(TCBS_CFG_RESET);
    end else if (cfg_wr) begin
      max_block_size_r <= cfg_pwdata[12:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(max_block_size_r);

  // The controller steps through the segmentation; the datapath holds all
  // operands and reports the decisions the controller branches on.
  tcbs_cmd_t cmd;
  tcbs_sts_t sts;

  tcbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcbs_dp #(
    .TB_SIZE_WIDTH (TB_SIZE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .tb_size         (in_tb_size),
    .max_block_size  (max_block_size_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_block_count (out_block_count),
    .out_large_size  (out_large_size),
    .out_large_index (out_large_index),
    .out_small_size  (out_small_size),
    .out_small_index (out_small_index),
    .out_large_count (out_large_count),
    .out_small_count (out_small_count),
    .out_filler_bits (out_filler_bits)
  );

  // Terms checked by the assertions below.
  logic err_word_clear;
  logic count_sum_ok;

  assign err_word_clear = (out_block_count == 15'd0) && (out_large_size == 13'd0) &&
                          (out_filler_bits == 6'd0);
  assign count_sum_ok   = (16'(out_large_count) + 16'(out_small_count)) ==
                          16'(out_block_count);

  // An error word carries nothing but the status bit.
  `TCBS_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status, err_word_clear)
  // The two block counts always add up to the total.
  `TCBS_ASSERT_IMP(a_count_sum, clk, rst_n, out_valid && !out_status, count_sum_ok)
  // The divider never runs while the block waits for a new word.
  `TCBS_ASSERT_IMP(a_idle_div, clk, rst_n, in_ready, !sts.div_busy)
  // One word is worked on at a time.
  `TCBS_ASSERT_NXT(a_one_word, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

/* src/tcbs_div.sv */
// Radix-4 restoring divider, two quotient bits per cycle.
module tcbs_div
  import tcbs_pkg::*;
#(
  parameter int DWE = TCBS_TB_SIZE_WIDTH + 6,
  parameter int VW  = TCBS_CNT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DWE-1:0] dividend,
  input  logic [VW-1:0]  divisor,
  output logic           busy,
  output logic           done,
  output logic [DWE-1:0] quotient
);

  localparam int STEPS = DWE / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DWE-1:0] acc_r, acc_nxt;
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [VW-1:0]  dv_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;

  logic [VW:0] r1, r2, dv_ext;
  logic [VW:0] r1s, r2s;
  logic        q1, q0;

  always_comb begin
    dv_ext  = {1'b0, dv_r};
    r1      = {rem_r, acc_r[DWE-1]};
    q1      = (r1 >= dv_ext);
    r1s     = q1 ? (r1 - dv_ext) : r1;
    r2      = {r1s[VW-1:0], acc_r[DWE-2]};
    q0      = (r2 >= dv_ext);
    r2s     = q0 ? (r2 - dv_ext) : r2;
    rem_nxt = r2s[VW-1:0];
    acc_nxt = {acc_r[DWE-3:0], q1, q0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = acc_r;

endmodule

/* src/tcbs_ctrl.sv */
// Sequencing state machine of the segmenter.
module tcbs_ctrl
  import tcbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcbs_sts_t sts,
  output tcbs_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_CNT  = 4'd3;
  localparam logic [3:0] S_D2GO = 4'd4;
  localparam logic [3:0] S_DIV2 = 4'd5;
  localparam logic [3:0] S_IDX  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_SUB  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  tcbs_kind_t kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          kind_nxt  = KIND_OK;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (sts.zero) begin
          kind_nxt  = KIND_ZERO;
          state_nxt = S_OUT;
        end else if (sts.fits) begin
          cmd.one_blk = 1'b1;
          state_nxt   = S_IDX;
        end else if (sts.z_small) begin
          kind_nxt  = KIND_ERR;
          state_nxt = S_OUT;
        end else begin
          cmd.div1_go = 1'b1;
          state_nxt   = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (sts.c_over) begin
          kind_nxt  = KIND_ERR;
          state_nxt = S_OUT;
        end else begin
          cmd.take_c = 1'b1;
          state_nxt  = S_D2GO;
        end
      end
      S_D2GO: begin
        cmd.div2_go = 1'b1;
        state_nxt   = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.take_need = 1'b1;
          state_nxt     = S_IDX;
        end
      end
      S_IDX: begin
        if (sts.need_big || (sts.multi && sts.idx_zero)) begin
          kind_nxt  = KIND_ERR;
          state_nxt = S_OUT;
        end else begin
          cmd.take_idx = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.take_prod = 1'b1;
        state_nxt     = S_SUB;
      end
      S_SUB: begin
        cmd.take_e = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.take_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_OK;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* src/tcbs_dp.sv */
// Segmentation datapath: operand registers, divider, table lookup and result register.
module tcbs_dp
  import tcbs_pkg::*;
#(
  parameter int TB_SIZE_WIDTH = TCBS_TB_SIZE_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tcbs_cmd_t                cmd,
  output tcbs_sts_t                sts,
  input  logic [TB_SIZE_WIDTH-1:0] tb_size,
  input  logic [12:0]              max_block_size,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic [14:0]              out_block_count,
  output logic [12:0]              out_large_size,
  output logic [7:0]               out_large_index,
  output logic [12:0]              out_small_size,
  output logic [7:0]               out_small_index,
  output logic [14:0]              out_large_count,
  output logic [14:0]              out_small_count,
  output logic [5:0]               out_filler_bits
);

  localparam int BW  = TB_SIZE_WIDTH + 1;
  localparam int DW  = TB_SIZE_WIDTH + 6;
  localparam int DWE = DW + (DW % 2);
  localparam int PW  = TCBS_CNT_W + TCBS_K_W;
  localparam int EW  = (DWE > PW) ? DWE : PW;
  localparam int RW  = 21;

  logic [BW-1:0]  b_r;
  logic           zero_r;
  logic           multi_r;
  logic [14:0]    c_r;
  logic [DWE-1:0] bp_r;
  logic [DWE-1:0] need_r;
  logic [7:0]     idx_r;
  logic [12:0]    k1_r;
  logic [PW-1:0]  prod_r;
  logic [RW-1:0]  e_r;

  logic           div_start, div_busy, div_done;
  logic [DWE-1:0] div_dividend, div_quot;
  logic [14:0]    div_divisor;
  logic [14:0]    quot_c;
  logic [EW-1:0]  e_full;
  logic [7:0]     idx_calc;

  always_comb begin
    div_start    = cmd.div1_go || cmd.div2_go;
    div_dividend = cmd.div1_go ? (DWE'(b_r) + DWE'(max_block_size) - DWE'(TCBS_CRC_BITS + 1))
                               : (bp_r - DWE'(1));
    div_divisor  = cmd.div1_go ? (15'(max_block_size) - 15'(TCBS_CRC_BITS)) : c_r;
  end

  tcbs_div #(
    .DWE (DWE),
    .VW  (TCBS_CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign quot_c   = div_quot[14:0];
  assign idx_calc = tcbs_tc_index(need_r[12:0]);
  assign e_full   = EW'(prod_r) - EW'(bp_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r    <= BW'(tb_size) + BW'(TCBS_CRC_BITS);
      zero_r <= (tb_size == '0);
    end
    if (cmd.one_blk) begin
      c_r     <= 15'd1;
      multi_r <= 1'b0;
      bp_r    <= DWE'(b_r);
      need_r  <= DWE'(b_r);
    end
    if (cmd.take_c) begin
      c_r     <= quot_c;
      multi_r <= 1'b1;
      // B' = B + 24*C, with 24*C formed as 16*C + 8*C.
      bp_r    <= DWE'(b_r) + DWE'({quot_c, 4'b0}) + DWE'({quot_c, 3'b0});
    end
    if (cmd.take_need) begin
      need_r <= div_quot + DWE'(1);
    end
    if (cmd.take_idx) begin
      idx_r <= idx_calc;
      k1_r  <= tcbs_tc_size(idx_calc);
    end
    if (cmd.take_prod) begin
      prod_r <= PW'(c_r) * PW'(k1_r);
    end
    if (cmd.take_e) begin
      e_r <= e_full[RW-1:0];
    end
  end

  // Adjacent table entries differ by a power of two, so C- and F come from
  // a shift and a mask of the excess E = C*K+ - B'.
  logic [2:0]    sh;
  logic [5:0]    fmask;
  logic [RW-1:0] c2_full;
  logic [14:0]   c2;
  logic [7:0]    idx2;
  logic [12:0]   k2;
  logic [5:0]    fill;

  always_comb begin
    priority if (idx_r < 8'd60) begin
      sh    = 3'd3;
      fmask = 6'h07;
    end else if (idx_r < 8'd92) begin
      sh    = 3'd4;
      fmask = 6'h0F;
    end else if (idx_r < 8'd124) begin
      sh    = 3'd5;
      fmask = 6'h1F;
    end else begin
      sh    = 3'd6;
      fmask = 6'h3F;
    end
    c2_full = e_r >> sh;
    idx2    = multi_r ? (idx_r - 8'd1) : 8'd0;
    k2      = multi_r ? tcbs_tc_size(idx_r - 8'd1) : 13'd0;
    c2      = multi_r ? c2_full[14:0] : 15'd0;
    fill    = multi_r ? (e_r[5:0] & fmask) : e_r[5:0];
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.take_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_out) begin
      out_status <= (cmd.kind == KIND_ERR);
      if (cmd.kind == KIND_OK) begin
        out_block_count <= c_r;
        out_large_size  <= k1_r;
        out_large_index <= idx_r;
        out_small_size  <= k2;
        out_small_index <= idx2;
        out_large_count <= c_r - c2;
        out_small_count <= c2;
        out_filler_bits <= fill;
      end else begin
        out_block_count <= '0;
        out_large_size  <= '0;
        out_large_index <= '0;
        out_small_size  <= '0;
        out_small_index <= '0;
        out_large_count <= '0;
        out_small_count <= '0;
        out_filler_bits <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts          = '0;
    sts.zero     = zero_r;
    sts.fits     = (b_r <= BW'(max_block_size));
    sts.z_small  = (max_block_size <= 13'(TCBS_CRC_BITS));
    sts.c_over   = |div_quot[DWE-1:15];
    sts.need_big = (need_r > DWE'(TCBS_MAX_K));
    sts.idx_zero = (idx_calc == 8'd0);
    sts.multi    = multi_r;
    sts.div_done = div_done;
    sts.div_busy = div_busy;
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

/* bench/turbo_code_block_segmenter_core_test.sv */
// Self-checking testbench for the turbo code block segmenter core.
module turbo_code_block_segmenter_core_test;
  import tcbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBW = TCBS_TB_SIZE_WIDTH;
  localparam longint unsigned TB_MAX = (64'd1 << TBW) - 1;
  localparam int CRC = TCBS_CRC_BITS;
  localparam int TABLE_ENTRIES = 188;
  localparam int COUNT_LIMIT = 32767;
  // Byte address of the maximum code block size register.
  localparam logic [2:0] REG_MAX_BLOCK_SIZE = 3'd0;
  // Cycles to let pass after the last result before reconfiguring or ending.
  // This covers one word still in flight, even a split block.
  localparam int SETTLE_CYCLES = 60;
  // Watchdog limit. The slowest correct run is roughly 1700 words, each
  // with its processing time, a sender gap and a long receiver stall,
  // which stays well under this limit.
  localparam int CYCLE_LIMIT = 800000;

  // One expected result word, one member per output port.
  typedef struct packed {
    logic        status;
    logic [14:0] block_count;
    logic [12:0] large_size;
    logic [7:0]  large_index;
    logic [12:0] small_size;
    logic [7:0]  small_index;
    logic [14:0] large_count;
    logic [14:0] small_count;
    logic [5:0]  filler_bits;
  } segmentation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [TBW-1:0] in_tb_size = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [14:0] out_block_count;
  logic [12:0] out_large_size;
  logic [7:0]  out_large_index;
  logic [12:0] out_small_size;
  logic [7:0]  out_small_index;
  logic [14:0] out_large_count;
  logic [14:0] out_small_count;
  logic [5:0]  out_filler_bits;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  turbo_code_block_segmenter_core #(
    .TB_SIZE_WIDTH(TBW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_tb_size     (in_tb_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_block_count(out_block_count),
    .out_large_size (out_large_size),
    .out_large_index(out_large_index),
    .out_small_size (out_small_size),
    .out_small_index(out_small_index),
    .out_large_count(out_large_count),
    .out_small_count(out_small_count),
    .out_filler_bits(out_filler_bits),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // Our own copy of the maximum code block size, tracking every write.
  logic [12:0] block_limit = 13'(TCBS_CFG_RESET);

  // Expected result words, oldest first.
  segmentation_t expected_segmentations[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  // Sender pacing: words go out in bursts with idle gaps between them.
  bit sender_gaps = 1'b1;
  int burst_left = 0;

  // Receiver stall pattern: a 16-bit mask that rotates every cycle and is
  // reloaded now and then with a new shape.
  logic [15:0] ready_mask = 16'hFFFF;
  int mask_age = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog. Any hang in either handshake ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[turbo_code_block_segmenter_core] ERROR");
      $finish;
    end
  end

  // Turbo interleaver size K at a table position. The table runs from 40 to
  // 512 in steps of 8, to 1024 in steps of 16, to 2048 in steps of 32 and to
  // 6144 in steps of 64.
  function automatic longint unsigned interleaver_size(input int unsigned pos);
    if (pos < 60) begin
      return 40 + 8 * pos;
    end else if (pos < 92) begin
      return 512 + 16 * (pos - 59);
    end else if (pos < 124) begin
      return 1024 + 32 * (pos - 91);
    end
    return 2048 + 64 * (pos - 123);
  endfunction

  // Predicts the segmentation of one transport block under limit z. Every
  // error case returns status 1 with all other fields cleared.
  function automatic segmentation_t segment_block(input logic [TBW-1:0] tbs,
                                                  input logic [12:0] z);
    longint unsigned b, c, bp, need, k1, k2, c1, c2, fill, span;
    int unsigned pos, pos_small;
    segmentation_t r;
    r = '0;
    if (tbs == 0) begin
      return r;
    end
    b = longint'(tbs) + CRC;
    if (b <= z) begin
      c = 1;
      bp = b;
    end else begin
      // With Z at or below the CRC length no code block can carry data.
      if (z <= CRC) begin
        r.status = 1'b1;
        return r;
      end
      span = z - CRC;
      c = (b + span - 1) / span;
      bp = b + CRC * c;
    end
    if (c > COUNT_LIMIT) begin
      r.status = 1'b1;
      return r;
    end
    need = (bp - 1) / c + 1;
    pos = 0;
    while (pos < TABLE_ENTRIES && interleaver_size(pos) < need) begin
      pos++;
    end
    if (pos == TABLE_ENTRIES) begin
      r.status = 1'b1;
      return r;
    end
    k1 = interleaver_size(pos);
    k2 = 0;
    c2 = 0;
    pos_small = 0;
    if (c == 1) begin
      c1 = 1;
    end else begin
      // A split block needs a smaller size below K+.
      if (pos == 0) begin
        r.status = 1'b1;
        return r;
      end
      pos_small = pos - 1;
      k2 = interleaver_size(pos_small);
      c2 = (c * k1 - bp) / (k1 - k2);
      c1 = c - c2;
    end
    fill = c1 * k1 + c2 * k2 - bp;
    r.block_count = 15'(c);
    r.large_size = 13'(k1);
    r.large_index = 8'(pos);
    r.small_size = 13'(k2);
    r.small_index = 8'(pos_small);
    r.large_count = 15'(c1);
    r.small_count = 15'(c2);
    r.filler_bits = 6'(fill);
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver and result checker. out_ready follows the rotating mask; each
  // accepted word is compared with the oldest prediction.
  always @(posedge clk) begin
    segmentation_t want;
    if (mask_age == 96) begin
      mask_age <= 0;
      case ($urandom_range(0, 3))
        0: ready_mask <= 16'hFFFF;
        1: ready_mask <= 16'($urandom()) | 16'h0001;
        2: ready_mask <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
        default: ready_mask <= 16'($urandom()) | 16'h8001;
      endcase
    end else begin
      mask_age <= mask_age + 1;
      ready_mask <= {ready_mask[14:0], ready_mask[15]};
    end
    out_ready <= ready_mask[15];

    if (rst_n && out_valid && out_ready) begin
      if (expected_segmentations.size() == 0) begin
        $error("result word arrived with no segmentation outstanding");
        mismatch_count++;
      end else begin
        want = expected_segmentations.pop_front();
        check_field("status", want.status, out_status);
        check_field("block_count", want.block_count, out_block_count);
        check_field("large_size", want.large_size, out_large_size);
        check_field("large_index", want.large_index, out_large_index);
        check_field("small_size", want.small_size, out_small_size);
        check_field("small_index", want.small_index, out_small_index);
        check_field("large_count", want.large_count, out_large_count);
        check_field("small_count", want.small_count, out_small_count);
        check_field("filler_bits", want.filler_bits, out_filler_bits);
      end
    end
  end

  // Offers one word and waits until it is taken. Valid stays high after
  // acceptance unless a gap follows, so back-to-back words never drop it.
  task automatic send_tb_size(input logic [TBW-1:0] size);
    in_valid <= 1'b1;
    in_tb_size <= size;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_segmentations.push_back(segment_block(size, block_limit));
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops offering words, waits for every outstanding result and lets the
  // block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_segmentations.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the maximum block size: setup cycle, then access cycle.
  // The upper data bits carry junk, which the register must ignore.
  task automatic write_block_limit(input logic [12:0] limit);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MAX_BLOCK_SIZE;
    cfg_pwdata <= {19'($urandom()), limit};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    block_limit = limit;
  endtask

  // Picks a transport block size, weighted toward the interesting regions:
  // single-block sizes, split boundaries of the current limit and table
  // boundaries, with some full-range values.
  function automatic logic [TBW-1:0] pick_tb_size(input logic [12:0] z);
    longint signed v;
    longint signed span;
    span = (z > CRC) ? longint'(z) - CRC : 1;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, int'(TB_MAX));
      1, 2, 3: v = $urandom_range(1, 6200);
      4, 5: v = $urandom_range(1, 70000);
      6: v = longint'($urandom_range(1, 40)) * span - CRC + $urandom_range(0, 4) - 2;
      7: v = longint'(interleaver_size($urandom_range(0, TABLE_ENTRIES - 1)))
             - CRC + $urandom_range(0, 2) - 1;
      8: begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = 1;
          default: v = TB_MAX;
        endcase
      end
      default: v = $urandom_range(1, 200000);
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > longint'(TB_MAX)) begin
      v = TB_MAX;
    end
    return TBW'(v);
  endfunction

  // Extremes of the size field under the reset limit: zero, the smallest
  // sizes, the single/split boundary and the largest size.
  task automatic test_default_limit_edges();
    sender_gaps = 1'b1;
    send_tb_size('0);
    send_tb_size(1);
    send_tb_size(16);
    send_tb_size(17);
    send_tb_size(6120);
    send_tb_size(6121);
    send_tb_size(12240);
    send_tb_size(12241);
    send_tb_size(TBW'(TB_MAX));
    drain_results();
  endtask

  // Each error case, reached through limits at and beyond the register's
  // usual range.
  task automatic test_error_cases();
    // A limit above the largest interleaver size lets one block need more
    // than 6144 bits: no table entry fits.
    write_block_limit(13'h1FFF);
    send_tb_size(6120);
    send_tb_size(6200);
    send_tb_size(8167);
    drain_results();
    // A limit of 40 leaves 16 data bits per block, so K+ lands on the first
    // entry with several blocks and there is no smaller size.
    write_block_limit(13'd40);
    send_tb_size(17);
    send_tb_size(16);
    drain_results();
    // A limit of 50 splits the largest block into more than 32767 blocks.
    write_block_limit(13'd50);
    send_tb_size(TBW'(TB_MAX));
    drain_results();
    // Limits at or below the CRC length leave no room for data.
    write_block_limit(13'd24);
    send_tb_size(1);
    drain_results();
    write_block_limit(13'd0);
    send_tb_size(1);
    drain_results();
    // Smallest limit of the normal range.
    write_block_limit(13'd64);
    send_tb_size(41);
    send_tb_size(TBW'(TB_MAX));
    drain_results();
  endtask

  // Random sizes under a sequence of limits, each phase with or without
  // sender gaps.
  task automatic test_random_limits();
    logic [12:0] limits[12];
    logic [12:0] z;
    limits[0] = 13'd6144;
    limits[1] = 13'd64;
    limits[2] = 13'h1FFF;
    limits[3] = 13'd512;
    limits[4] = 13'd25;
    limits[5] = 13'd40;
    limits[6] = 13'd1000;
    limits[7] = 13'd6143;
    for (int k = 8; k < 12; k++) begin
      limits[k] = 13'($urandom_range(64, TCBS_MAX_K));
    end
    for (int phase = 0; phase < 12; phase++) begin
      z = limits[phase];
      write_block_limit(z);
      sender_gaps = (phase % 3) != 1;
      burst_left = 0;
      for (int n = 0; n < 137; n++) begin
        send_tb_size(pick_tb_size(z));
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_limit_edges();
    test_error_cases();
    test_random_limits();
    drain_results();

    if (mismatch_count == 0) begin
      $display("[turbo_code_block_segmenter_core] OK");
    end else begin
      $display("[turbo_code_block_segmenter_core] ERROR");
    end
    $finish;
  end

endmodule
